// ----- rtl/core/ldc_pkg.sv -----
// ----------------------------------------------------------------------------
// ldc_pkg
// Shared constants, types and the logistic lookup table of the linear
// discriminant classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ldc_pkg;

   localparam int MAX_FEATURES    = 64;
   localparam int SAMPLE_BITS     = 16;
   localparam int SIGMOID_ENTRIES = 256;

   localparam int ADDR_BITS    = $clog2(MAX_FEATURES);
   localparam int CNT_BITS     = $clog2(MAX_FEATURES + 2);
   localparam int FCOUNT_BITS  = 7;
   localparam int WIDX_BITS    = 6;
   localparam int PROD_BITS    = 2 * SAMPLE_BITS;
   localparam int ACC_BITS     = 48;
   localparam int LABEL_BITS   = 16;
   localparam int PROB_BITS    = 16;
   localparam int SIG_IDX_BITS = $clog2(SIGMOID_ENTRIES);
   localparam int SIG_HALF     = SIGMOID_ENTRIES / 2;

   // score is Q24.24, the table spans [-8, 8)
   localparam int SCORE_FRAC   = 24;
   localparam int SIG_SHIFT    = SCORE_FRAC + 3;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = ACC_BITS;

   localparam int OUT_DEPTH     = 8;
   localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);
   localparam int FILL_BITS     = $clog2(OUT_DEPTH + 4);

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] SIG_HI  = ACC_BITS'(longint'(1) << SIG_SHIFT);
   localparam logic signed [ACC_BITS-1:0] SIG_LO  = -SIG_HI;

   typedef enum logic {
      OP_WEIGHT  = 1'b0,
      OP_FEATURE = 1'b1
   } op_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_FEATURE_COUNT = 2'd0,
      CSR_BIAS          = 2'd1,
      CSR_FIRST_LABEL   = 2'd2,
      CSR_SECOND_LABEL  = 2'd3
   } csr_index_type;

   // one weight write into the store
   typedef struct packed {
      logic                          en;
      logic [ADDR_BITS-1:0]          addr;
      logic signed [SAMPLE_BITS-1:0] data;
   } ldc_wr_type;

   // one feature element entering the multiply-accumulate
   typedef struct packed {
      logic                          valid;
      logic                          last;
      logic                          in_range;
      logic                          len_err;
      logic [ADDR_BITS-1:0]          addr;
      logic signed [SAMPLE_BITS-1:0] sample;
   } ldc_feat_type;

   // finished dot product of one vector
   typedef struct packed {
      logic                       valid;
      logic                       len_err;
      logic signed [ACC_BITS-1:0] acc;
   } ldc_sum_type;

   typedef struct packed {
      logic [LABEL_BITS-1:0]      class_label;
      logic [PROB_BITS-1:0]       probability;
      logic signed [ACC_BITS-1:0] score;
      logic                       length_error;
   } ldc_result_type;

   typedef logic [PROB_BITS-1:0] sig_rom_type [SIGMOID_ENTRIES];

   // restoring long division, used only while the table is built
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // 1/(1+exp(-a)) in Q0.16, a = (i - N/2) * 16/N; evaluated at elaboration
   function automatic sig_rom_type build_sig_rom();
      sig_rom_type rom;
      logic [63:0] term;
      logic [63:0] total;
      logic [63:0] base;
      logic [63:0] p;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] v;
      logic [63:0] pw [0:SIG_HALF];
      term  = 64'd1 << 58;
      total = term;
      for (int n = 1; n <= 20; n++) begin
         term = udiv64(term * 64'd16, 64'(SIGMOID_ENTRIES) * 64'(n));
         if ((n & 1) != 0) begin
            total = total - term;
         end else begin
            total = total + term;
         end
      end
      base  = (total + (64'd1 << 27)) >> 28;
      pw[0] = 64'd1 << 30;
      for (int n = 1; n <= SIG_HALF; n++) begin
         pw[n] = (pw[n-1] * base + (64'd1 << 29)) >> 30;
      end
      for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
         if (i >= SIG_HALF) begin
            p   = pw[i - SIG_HALF];
            num = 64'd1 << 46;
         end else begin
            p   = pw[SIG_HALF - i];
            num = p << 16;
         end
         den = (64'd1 << 30) + p;
         v   = udiv64(num + (den >> 1), den);
         rom[i] = (v > 64'd65535) ? {PROB_BITS{1'b1}} : v[PROB_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_sig_rom();

endpackage

`default_nettype wire

// ----- rtl/core/ldc_mac.sv -----
// ----------------------------------------------------------------------------
// ldc_mac
// Weight store, weight/feature register stage and saturating accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_mac (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ldc_pkg::ldc_wr_type   wr_in,
   input  wire ldc_pkg::ldc_feat_type feat_in,
   output ldc_pkg::ldc_sum_type       sum_out,
   output logic                       s1_last_out
);

   logic signed [ldc_pkg::SAMPLE_BITS-1:0] mem [ldc_pkg::MAX_FEATURES];

   logic                                   s1_valid_ff;
   logic                                   s1_last_ff;
   logic                                   s1_in_range_ff;
   logic                                   s1_len_err_ff;
   logic signed [ldc_pkg::SAMPLE_BITS-1:0] s1_weight_ff;
   logic signed [ldc_pkg::SAMPLE_BITS-1:0] s1_sample_ff;

   logic signed [ldc_pkg::PROD_BITS-1:0]   prod;
   logic signed [ldc_pkg::ACC_BITS:0]      acc_wide;
   logic signed [ldc_pkg::ACC_BITS-1:0]    acc_sat;
   logic signed [ldc_pkg::ACC_BITS-1:0]    acc_ff;
   logic signed [ldc_pkg::ACC_BITS-1:0]    acc_in;

   logic                                   s2_valid_ff;
   logic                                   s2_len_err_ff;
   logic signed [ldc_pkg::ACC_BITS-1:0]    s2_acc_ff;

   always_ff @(posedge clock) begin
      if (wr_in.en) begin
         mem[wr_in.addr] <= wr_in.data;
      end
      if (feat_in.valid) begin
         s1_weight_ff <= mem[feat_in.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= feat_in.valid;
         s1_last_ff  <= feat_in.valid & feat_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (feat_in.valid) begin
         s1_sample_ff   <= feat_in.sample;
         s1_in_range_ff <= feat_in.in_range;
         s1_len_err_ff  <= feat_in.len_err;
      end
   end

   // elements past the store add nothing
   always_comb begin
      prod = '0;
      if (s1_in_range_ff) begin
         prod = s1_weight_ff * s1_sample_ff;
      end
   end

   assign acc_wide = (ldc_pkg::ACC_BITS+1)'(acc_ff) + (ldc_pkg::ACC_BITS+1)'(prod);

   always_comb begin
      if (acc_wide[ldc_pkg::ACC_BITS] != acc_wide[ldc_pkg::ACC_BITS-1]) begin
         acc_sat = acc_wide[ldc_pkg::ACC_BITS] ? ldc_pkg::ACC_MIN : ldc_pkg::ACC_MAX;
      end else begin
         acc_sat = acc_wide[ldc_pkg::ACC_BITS-1:0];
      end
      acc_in = acc_ff;
      if (s1_valid_ff) begin
         acc_in = s1_last_ff ? '0 : acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         acc_ff      <= acc_in;
         s2_valid_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_last_ff) begin
         s2_acc_ff     <= acc_sat;
         s2_len_err_ff <= s1_len_err_ff;
      end
   end

   assign sum_out.valid   = s2_valid_ff;
   assign sum_out.len_err = s2_len_err_ff;
   assign sum_out.acc     = s2_acc_ff;
   assign s1_last_out     = s1_last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ldc_score.sv -----
// ----------------------------------------------------------------------------
// ldc_score
// Bias add with saturation, then logistic lookup and class selection.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_score (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ldc_pkg::ldc_sum_type                   sum_in,
   input  wire logic signed [ldc_pkg::ACC_BITS-1:0]    bias,
   input  wire logic [ldc_pkg::LABEL_BITS-1:0]         first_label,
   input  wire logic [ldc_pkg::LABEL_BITS-1:0]         second_label,
   output logic                                        push_out,
   output ldc_pkg::ldc_result_type                     result_out
);

   logic signed [ldc_pkg::ACC_BITS:0]   score_wide;
   logic signed [ldc_pkg::ACC_BITS-1:0] score_in;
   logic signed [ldc_pkg::ACC_BITS-1:0] score_ff;
   logic                                len_err_ff;
   logic                                valid_ff;
   logic [ldc_pkg::ACC_BITS-1:0]        offset;
   logic [ldc_pkg::SIG_IDX_BITS-1:0]    sig_idx;

   assign score_wide = (ldc_pkg::ACC_BITS+1)'(sum_in.acc) + (ldc_pkg::ACC_BITS+1)'(bias);

   always_comb begin
      if (score_wide[ldc_pkg::ACC_BITS] != score_wide[ldc_pkg::ACC_BITS-1]) begin
         score_in = score_wide[ldc_pkg::ACC_BITS] ? ldc_pkg::ACC_MIN : ldc_pkg::ACC_MAX;
      end else begin
         score_in = score_wide[ldc_pkg::ACC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sum_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_in.valid) begin
         score_ff   <= score_in;
         len_err_ff <= sum_in.len_err;
      end
   end

   // clamp to [-8, 8) then take the top index bits of score + 8
   assign offset = score_ff - ldc_pkg::SIG_LO;

   always_comb begin
      if (score_ff < ldc_pkg::SIG_LO) begin
         sig_idx = '0;
      end else if (score_ff >= ldc_pkg::SIG_HI) begin
         sig_idx = '1;
      end else begin
         sig_idx = offset[ldc_pkg::SIG_SHIFT -: ldc_pkg::SIG_IDX_BITS];
      end
   end

   assign push_out                = valid_ff;
   assign result_out.class_label  = score_ff[ldc_pkg::ACC_BITS-1] ? second_label : first_label;
   assign result_out.probability  = ldc_pkg::SIG_ROM[sig_idx];
   assign result_out.score        = score_ff;
   assign result_out.length_error = len_err_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ldc_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ldc_out_fifo
// Small result queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_out_fifo (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire ldc_pkg::ldc_result_type          push_data,
   input  wire logic                             pop,
   output logic                                  not_empty,
   output ldc_pkg::ldc_result_type               head,
   output logic [ldc_pkg::OUT_CNT_BITS-1:0]      level
);

   ldc_pkg::ldc_result_type               slot_ff [ldc_pkg::OUT_DEPTH];
   logic [ldc_pkg::OUT_PTR_BITS-1:0]      wr_ptr_ff;
   logic [ldc_pkg::OUT_PTR_BITS-1:0]      rd_ptr_ff;
   logic [ldc_pkg::OUT_CNT_BITS-1:0]      count_ff;
   logic [ldc_pkg::OUT_CNT_BITS-1:0]      count_in;
   logic                                  do_pop;

   assign do_pop = pop & (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

`default_nettype wire

// ----- rtl/core/linear_discriminant_classify.sv -----
// ----------------------------------------------------------------------------
// linear_discriminant_classify
// Two-class linear discriminant: weight store, streaming multiply-accumulate,
// bias, logistic lookup and class decision.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_      in   tvalid/tready      tdata {sample, weight_index}, tuser opcode,
//                                    tlast end of vector
//  rsp_      out  tvalid/tready      tdata {score, probability, class_label},
//                                    tuser length_error
//  csr_      in   wen, no handshake  addr register index, wdata value
//
//  One request per cycle while req_tready is high; after its last element is
//  taken, a result passes store read, multiply-accumulate, bias and lookup.
//  req_tready drops only when the eight-entry result queue plus results still
//  in the pipeline would fill it, so a stalled rsp_ side stops intake.
//  Synchronous reset clears control, the accumulator and the element count;
//  the weight store holds whatever was last written.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_discriminant_classify (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [23:0]                           req_tdata,  // weight_index, sample
   input  wire logic                                  req_tuser,  // opcode
   input  wire logic                                  req_tlast,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [79:0]                                rsp_tdata,  // class_label, probability, score
   output logic                                       rsp_tuser,  // length_error
   input  wire logic                                  csr_wen,
   input  wire logic [ldc_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  wire logic [ldc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [ldc_pkg::FCOUNT_BITS-1:0]        feature_count_ff;
   logic signed [ldc_pkg::ACC_BITS-1:0]    bias_ff;
   logic [ldc_pkg::LABEL_BITS-1:0]         first_label_ff;
   logic [ldc_pkg::LABEL_BITS-1:0]         second_label_ff;

   logic [ldc_pkg::CNT_BITS-1:0]           count_ff;
   logic [ldc_pkg::CNT_BITS-1:0]           count_inc;
   logic [ldc_pkg::CNT_BITS-1:0]           count_in;

   logic                                   accept;
   logic                                   is_feature;
   logic [ldc_pkg::WIDX_BITS-1:0]          weight_index;
   logic signed [ldc_pkg::SAMPLE_BITS-1:0] sample;

   ldc_pkg::ldc_wr_type                    wr;
   ldc_pkg::ldc_feat_type                  feat;
   ldc_pkg::ldc_sum_type                   sum;
   ldc_pkg::ldc_result_type                result;
   ldc_pkg::ldc_result_type                head;
   logic                                   s1_last;
   logic                                   push;
   logic [ldc_pkg::OUT_CNT_BITS-1:0]       level;
   logic [ldc_pkg::FILL_BITS-1:0]          fill;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         feature_count_ff <= ldc_pkg::FCOUNT_BITS'(1);
         bias_ff          <= '0;
         first_label_ff   <= '0;
         second_label_ff  <= ldc_pkg::LABEL_BITS'(1);
      end else if (csr_wen) begin
         case (ldc_pkg::csr_index_type'(csr_addr))
            ldc_pkg::CSR_FEATURE_COUNT: begin
               feature_count_ff <= csr_wdata[ldc_pkg::FCOUNT_BITS-1:0];
            end
            ldc_pkg::CSR_BIAS: begin
               bias_ff <= csr_wdata[ldc_pkg::ACC_BITS-1:0];
            end
            ldc_pkg::CSR_FIRST_LABEL: begin
               first_label_ff <= csr_wdata[ldc_pkg::LABEL_BITS-1:0];
            end
            ldc_pkg::CSR_SECOND_LABEL: begin
               second_label_ff <= csr_wdata[ldc_pkg::LABEL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign weight_index = req_tdata[ldc_pkg::WIDX_BITS-1:0];
   assign sample       = req_tdata[ldc_pkg::WIDX_BITS +: ldc_pkg::SAMPLE_BITS];
   assign is_feature   = ldc_pkg::op_type'(req_tuser) == ldc_pkg::OP_FEATURE;

   // hold back intake when queued plus in-flight results could overrun the queue
   assign fill = ldc_pkg::FILL_BITS'(level) + ldc_pkg::FILL_BITS'(s1_last)
               + ldc_pkg::FILL_BITS'(sum.valid) + ldc_pkg::FILL_BITS'(push);
   assign req_tready = fill < ldc_pkg::FILL_BITS'(ldc_pkg::OUT_DEPTH);
   assign accept     = req_tvalid & req_tready;

   // element count saturates one past the store depth
   assign count_inc = (32'(count_ff) <= ldc_pkg::MAX_FEATURES) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      count_in = count_ff;
      if (accept && is_feature) begin
         count_in = req_tlast ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign wr.en   = accept & !is_feature & (32'(weight_index) < ldc_pkg::MAX_FEATURES);
   assign wr.addr = ldc_pkg::ADDR_BITS'(weight_index);
   assign wr.data = sample;

   assign feat.valid    = accept & is_feature;
   assign feat.last     = req_tlast;
   assign feat.in_range = 32'(count_ff) < ldc_pkg::MAX_FEATURES;
   assign feat.len_err  = 32'(count_inc) != 32'(feature_count_ff);
   assign feat.addr     = count_ff[ldc_pkg::ADDR_BITS-1:0];
   assign feat.sample   = sample;

   ldc_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .wr_in       (wr),
      .feat_in     (feat),
      .sum_out     (sum),
      .s1_last_out (s1_last)
   );

   ldc_score u_score (
      .clock        (clock),
      .reset        (reset),
      .sum_in       (sum),
      .bias         (bias_ff),
      .first_label  (first_label_ff),
      .second_label (second_label_ff),
      .push_out     (push),
      .result_out   (result)
   );

   ldc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .head      (head),
      .level     (level)
   );

   assign rsp_tdata = {head.score, head.probability, head.class_label};
   assign rsp_tuser = head.length_error;

endmodule

`default_nettype wire

// ----- rtl/core/ldc_checker.sv -----
// ----------------------------------------------------------------------------
// ldc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ldc_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   input  wire logic                                  req_tready,
   input  wire logic                                  req_tuser,
   input  wire logic                                  req_tlast,
   input  wire logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic [79:0]                           rsp_tdata,
   input  wire logic                                  rsp_tuser
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // the queue is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // intake stops only while a result is waiting
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("intake stalled with no result pending");

   // the last element of a vector produces a pending result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ldc_pkg::OP_FEATURE && req_tlast
      |-> ##4 rsp_tvalid)
      else $error("no result after last element");

endmodule

bind linear_discriminant_classify ldc_checker u_ldc_checker (.*);

`default_nettype wire
